>>> hdl/range_list_id_allocator_core_assert.svh
// assertion macros shared by the allocator rtl
// expects clk and arst_n in the scope of the module that includes it
`ifndef RANGE_LIST_ID_ALLOCATOR_CORE_ASSERT_SVH
`define RANGE_LIST_ID_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define LRAL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lral check failed");

// next-cycle implication, held off during reset
`define LRAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lral check failed");

`endif

>>> hdl/lral_pkg.sv
// types and constants of the range list id allocator
// no dependencies
`timescale 1ns / 1ps

package lral_pkg;

	localparam int ID_W       = 32;
	localparam int MAX_RANGES = 64;
	localparam int PTR_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int CFG_IDX_W  = 1;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_EXHAUSTED  = 2'd1;
	localparam status_t ST_NOT_FREE   = 2'd2;
	localparam status_t ST_TABLE_FULL = 2'd3;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_EXCLUDE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_BEGIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'd1;

	typedef struct packed {
		logic [ID_W-1:0] hi;
		logic [ID_W-1:0] lo;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hdl/lral_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lral_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AddrW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/range_list_id_allocator_core.sv
// range list id allocator: sequencer over a single range table ram
// depends on lral_pkg, lral_ram and range_list_id_allocator_core_assert.svh
//
// channel   ports                                   transfer
// command   start, busy, kind, target_id, strict    start high while busy low
// result    done, granted_id, status, free_count    done high for one cycle
// config    reg_we, reg_idx, reg_wdata              reg_we high
//
// allocate reads and trims the top range; exclude scans the ranges from entry 0 up,
// then moves the ranges above on a drop or split and writes the two halves of a split;
// all of it is paced by the one ram read port.
// the first command after reset or a config write first loads the configured range
// into entry 0.
// reset empties the list; the result side cannot stall.
`timescale 1ns / 1ps
`include "range_list_id_allocator_core_assert.svh"

module range_list_id_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [lral_pkg::ID_W-1:0]     target_id,
	input  logic                          strict,
	output logic                          done,
	output logic [lral_pkg::ID_W-1:0]     granted_id,
	output lral_pkg::status_t             status,
	output logic [lral_pkg::ID_W-1:0]     free_count,
	input  logic                          reg_we,
	input  logic [lral_pkg::CFG_IDX_W-1:0] reg_idx,
	input  logic [lral_pkg::ID_W-1:0]     reg_wdata
);

	import lral_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SETUP,
		S_AWAIT,
		S_AUPD,
		S_SWAIT,
		S_SCHK,
		S_DWAIT,
		S_DWR,
		S_UWAIT,
		S_UWR,
		S_SPLIT_HI,
		S_SPLIT_LO
	} state_t;

	state_t           state_q;
	logic             kind_q;
	logic [ID_W-1:0]  id_q;
	logic             strict_q;
	logic             fresh_q;
	logic [ID_W-1:0]  begin_q;
	logic [ID_W-1:0]  end_q;
	logic [CNT_W-1:0] count_q;
	logic [ID_W-1:0]  free_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] hit_q;
	logic [ID_W-1:0]  cur_lo_q;
	logic [ID_W-1:0]  cur_hi_q;
	logic             done_q;
	logic [ID_W-1:0]  granted_q;
	status_t          status_q;
	logic [ID_W-1:0]  free_out_q;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	entry_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;

	logic [ID_W-1:0] lo_inc;
	logic [ID_W-1:0] id_inc;
	logic            below_hi;
	logic            below_lo;
	logic            at_lo;
	logic            lo_empties;
	logic            id_is_top;
	logic            more_ranges;
	logic [ID_W-1:0] free_dec;
	status_t         miss_status;

	logic [ID_W-1:0] cfg_begin;
	logic [ID_W-1:0] cfg_end;
	logic            cfg_valid;

	lral_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign rd_entry    = entry_t'(ram_rdata);
	assign lo_inc      = rd_entry.lo + ID_W'(1);
	assign id_inc      = id_q + ID_W'(1);
	assign below_hi    = id_q < rd_entry.hi;
	assign below_lo    = id_q < rd_entry.lo;
	assign at_lo       = id_q == rd_entry.lo;
	assign lo_empties  = lo_inc == rd_entry.hi;
	assign id_is_top   = id_inc == rd_entry.hi;
	assign more_ranges = (CNT_W'(ptr_q) + CNT_W'(1)) < count_q;
	assign free_dec    = free_q - ID_W'(1);
	assign miss_status = strict_q ? ST_NOT_FREE : ST_OK;

	always_comb begin
		cfg_begin = begin_q;
		cfg_end   = end_q;
		unique case (reg_idx)
			REG_RANGE_BEGIN: cfg_begin = reg_wdata;
			REG_RANGE_END:   cfg_end   = reg_wdata;
			default: ;
		endcase
	end

	assign cfg_valid = cfg_begin < cfg_end;

	// table write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = rd_entry;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = '{hi: end_q, lo: begin_q};
			end
			S_AUPD: begin
				ram_we    = !lo_empties;
				ram_wdata = '{hi: rd_entry.hi, lo: lo_inc};
			end
			S_SCHK: begin
				if (below_hi && at_lo && !lo_empties) begin
					ram_we    = 1'b1;
					ram_wdata = '{hi: rd_entry.hi, lo: lo_inc};
				end else if (below_hi && !below_lo && !at_lo && id_is_top) begin
					ram_we    = 1'b1;
					ram_wdata = '{hi: id_q, lo: rd_entry.lo};
				end
			end
			S_DWR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q - PTR_W'(1);
			end
			S_UWR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + PTR_W'(1);
			end
			S_SPLIT_HI: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q + PTR_W'(1);
				ram_wdata = '{hi: cur_hi_q, lo: id_inc};
			end
			S_SPLIT_LO: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q;
				ram_wdata = '{hi: id_q, lo: cur_lo_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= KIND_ALLOC;
			id_q       <= '0;
			strict_q   <= 1'b0;
			fresh_q    <= 1'b1;
			begin_q    <= '0;
			end_q      <= '0;
			count_q    <= '0;
			free_q     <= '0;
			ptr_q      <= '0;
			hit_q      <= '0;
			cur_lo_q   <= '0;
			cur_hi_q   <= '0;
			done_q     <= 1'b0;
			granted_q  <= '0;
			status_q   <= ST_OK;
			free_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q   <= kind;
						id_q     <= target_id;
						strict_q <= strict;
						state_q  <= fresh_q ? S_INIT : S_SETUP;
					end
				end
				S_INIT: begin
					fresh_q <= 1'b0;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (count_q == '0) begin
						done_q     <= 1'b1;
						granted_q  <= '0;
						status_q   <= (kind_q == KIND_ALLOC) ? ST_EXHAUSTED : miss_status;
						free_out_q <= free_q;
						state_q    <= S_IDLE;
					end else if (kind_q == KIND_ALLOC) begin
						ptr_q   <= PTR_W'(count_q - CNT_W'(1));
						state_q <= S_AWAIT;
					end else begin
						ptr_q   <= '0;
						state_q <= S_SWAIT;
					end
				end
				S_AWAIT: begin
					state_q <= S_AUPD;
				end
				S_AUPD: begin
					if (lo_empties) begin
						count_q <= count_q - CNT_W'(1);
					end
					if (free_q != '0) begin
						free_q     <= free_dec;
						free_out_q <= free_dec;
					end else begin
						free_out_q <= free_q;
					end
					done_q    <= 1'b1;
					granted_q <= rd_entry.lo;
					status_q  <= ST_OK;
					state_q   <= S_IDLE;
				end
				S_SWAIT: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					hit_q    <= ptr_q;
					cur_lo_q <= rd_entry.lo;
					cur_hi_q <= rd_entry.hi;
					if (!below_hi) begin
						if (more_ranges) begin
							ptr_q   <= ptr_q + PTR_W'(1);
							state_q <= S_SWAIT;
						end else begin
							done_q     <= 1'b1;
							granted_q  <= '0;
							status_q   <= miss_status;
							free_out_q <= free_q;
							state_q    <= S_IDLE;
						end
					end else if (below_lo) begin
						done_q     <= 1'b1;
						granted_q  <= '0;
						status_q   <= miss_status;
						free_out_q <= free_q;
						state_q    <= S_IDLE;
					end else if ((at_lo && lo_empties) && more_ranges) begin
						// drop with entries above: close the gap first
						free_q  <= free_dec;
						ptr_q   <= ptr_q + PTR_W'(1);
						state_q <= S_DWAIT;
					end else if (at_lo || id_is_top) begin
						if (at_lo && lo_empties) begin
							count_q <= count_q - CNT_W'(1);
						end
						free_q     <= free_dec;
						done_q     <= 1'b1;
						granted_q  <= '0;
						status_q   <= ST_OK;
						free_out_q <= free_dec;
						state_q    <= S_IDLE;
					end else if (count_q == CNT_W'(MAX_RANGES)) begin
						done_q     <= 1'b1;
						granted_q  <= '0;
						status_q   <= ST_TABLE_FULL;
						free_out_q <= free_q;
						state_q    <= S_IDLE;
					end else if (more_ranges) begin
						// split with entries above: move them up from the top
						ptr_q   <= PTR_W'(count_q - CNT_W'(1));
						state_q <= S_UWAIT;
					end else begin
						state_q <= S_SPLIT_HI;
					end
				end
				S_DWAIT: begin
					state_q <= S_DWR;
				end
				S_DWR: begin
					if (more_ranges) begin
						ptr_q   <= ptr_q + PTR_W'(1);
						state_q <= S_DWAIT;
					end else begin
						count_q    <= count_q - CNT_W'(1);
						done_q     <= 1'b1;
						granted_q  <= '0;
						status_q   <= ST_OK;
						free_out_q <= free_q;
						state_q    <= S_IDLE;
					end
				end
				S_UWAIT: begin
					state_q <= S_UWR;
				end
				S_UWR: begin
					if (CNT_W'(ptr_q) > (CNT_W'(hit_q) + CNT_W'(1))) begin
						ptr_q   <= ptr_q - PTR_W'(1);
						state_q <= S_UWAIT;
					end else begin
						state_q <= S_SPLIT_HI;
					end
				end
				S_SPLIT_HI: begin
					state_q <= S_SPLIT_LO;
				end
				S_SPLIT_LO: begin
					count_q    <= count_q + CNT_W'(1);
					free_q     <= free_dec;
					done_q     <= 1'b1;
					granted_q  <= '0;
					status_q   <= ST_OK;
					free_out_q <= free_dec;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// config reloads the list from both range registers
			if (reg_we) begin
				begin_q <= cfg_begin;
				end_q   <= cfg_end;
				fresh_q <= 1'b1;
				count_q <= cfg_valid ? CNT_W'(1) : '0;
				free_q  <= cfg_valid ? (cfg_end - cfg_begin) : '0;
			end
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign granted_id = granted_q;
	assign status     = status_q;
	assign free_count = free_out_q;

	`LRAL_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_RANGES))
	`LRAL_ASSERT_IMPL(a_empty_no_free, count_q == '0, free_q == '0)
	`LRAL_ASSERT_IMPL(a_done_idle, done_q, state_q == S_IDLE)
	`LRAL_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`LRAL_ASSERT_IMPL(a_full_on_exclude, done_q && status_q == ST_TABLE_FULL, kind_q == KIND_EXCLUDE)

endmodule

>>> tb/range_list_id_allocator_core_tb.sv
// self-checking testbench for range_list_id_allocator_core: directed table then random phases
// keeps a copy of the free range list, checks every result strobe against it or typed rows
// depends on lral_pkg and the allocator rtl
`timescale 1ns / 1ps

module range_list_id_allocator_core_tb;

	import lral_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int RANDOM_ITEMS = 1880;

	typedef struct packed {
		logic [ID_W-1:0] granted;
		status_t         status;
		logic [ID_W-1:0] free_cnt;
	} grant_result_t;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [ID_W-1:0]      data;
		logic                 kind;
		logic [ID_W-1:0]      id;
		logic                 strict;
		bit                   typed;
		grant_result_t        want;
	} plan_row_t;

	typedef enum {PH_FRAGMENT, PH_MIXED, PH_NOISE} phase_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 kind      = KIND_ALLOC;
	logic [ID_W-1:0]      target_id = '0;
	logic                 strict    = 1'b0;
	logic                 reg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] reg_idx   = REG_RANGE_BEGIN;
	logic [ID_W-1:0]      reg_wdata = '0;
	logic                 busy;
	logic                 done;
	logic [ID_W-1:0]      granted_id;
	status_t              status;
	logic [ID_W-1:0]      free_count;

	// free range list as the block should hold it
	logic [ID_W-1:0] lo_tab [MAX_RANGES];
	logic [ID_W-1:0] hi_tab [MAX_RANGES];
	int unsigned     n_ranges;
	logic [ID_W-1:0] free_ids;
	logic [ID_W-1:0] cfg_begin;
	logic [ID_W-1:0] cfg_end;

	grant_result_t pending_results[$];
	plan_row_t     plan[$];

	int  cycle_count;
	int  fail_count;
	int  alloc_sent;
	int  exclude_sent;
	int  reg_writes;
	int  random_items;
	int  status_seen [4];
	bit  quiet_phase;

	range_list_id_allocator_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.target_id  (target_id),
		.strict     (strict),
		.done       (done),
		.granted_id (granted_id),
		.status     (status),
		.free_count (free_count),
		.reg_we     (reg_we),
		.reg_idx    (reg_idx),
		.reg_wdata  (reg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void add_plan_row(plan_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	function automatic void expect_result(grant_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void reload_ranges();
		for (int k = 0; k < MAX_RANGES; k++) begin
			lo_tab[k] = '0;
			hi_tab[k] = '0;
		end
		n_ranges = 0;
		free_ids = '0;
		if (cfg_begin < cfg_end) begin
			lo_tab[0] = cfg_begin;
			hi_tab[0] = cfg_end;
			n_ranges  = 1;
			free_ids  = cfg_end - cfg_begin;
		end
	endfunction

	function automatic void drop_range(int unsigned pos);
		for (int unsigned k = pos; k + 1 < n_ranges; k++) begin
			lo_tab[k] = lo_tab[k + 1];
			hi_tab[k] = hi_tab[k + 1];
		end
		n_ranges--;
		lo_tab[n_ranges] = '0;
		hi_tab[n_ranges] = '0;
	endfunction

	function automatic grant_result_t serve_request(logic req_kind, logic [ID_W-1:0] id,
		logic req_strict);
		grant_result_t   r;
		int unsigned     last;
		bit              found;
		logic [ID_W:0]   nxt;
		logic [ID_W-1:0] upper;
		r = '0;
		r.status = ST_OK;
		if (req_kind == KIND_ALLOC) begin
			if (n_ranges == 0) begin
				r.status = ST_EXHAUSTED;
			end else begin
				last = n_ranges - 1;
				r.granted = lo_tab[last];
				lo_tab[last]++;
				free_ids--;
				if (lo_tab[last] >= hi_tab[last]) begin
					lo_tab[last] = '0;
					hi_tab[last] = '0;
					n_ranges--;
				end
			end
		end else begin
			r.status = req_strict ? ST_NOT_FREE : ST_OK;
			found = 1'b0;
			for (int unsigned i = 0; i < n_ranges && !found; i++) begin
				if (id == lo_tab[i]) begin
					// trim the low end, drop the range once empty
					lo_tab[i]++;
					if (lo_tab[i] == hi_tab[i])
						drop_range(i);
					free_ids--;
					r.status = ST_OK;
					found = 1'b1;
				end else if (id < lo_tab[i]) begin
					found = 1'b1;
				end else if (id < hi_tab[i]) begin
					found = 1'b1;
					upper = hi_tab[i];
					nxt   = {1'b0, id} + 1'b1;
					if (nxt < {1'b0, upper} && n_ranges >= MAX_RANGES) begin
						r.status = ST_TABLE_FULL;
					end else begin
						if (nxt < {1'b0, upper}) begin
							for (int unsigned k = n_ranges; k > i + 1; k--) begin
								lo_tab[k] = lo_tab[k - 1];
								hi_tab[k] = hi_tab[k - 1];
							end
							lo_tab[i + 1] = nxt[ID_W-1:0];
							hi_tab[i + 1] = upper;
							n_ranges++;
						end
						hi_tab[i] = id;
						free_ids--;
						r.status = ST_OK;
					end
				end
			end
		end
		r.free_cnt = free_ids;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		return row;
	endfunction

	function automatic plan_row_t cmd_row(logic req_kind, logic [ID_W-1:0] id, logic req_strict);
		plan_row_t row;
		row = '{default: '0};
		row.kind   = req_kind;
		row.id     = id;
		row.strict = req_strict;
		return row;
	endfunction

	function automatic plan_row_t typed_row(logic req_kind, logic [ID_W-1:0] id,
		logic req_strict, logic [ID_W-1:0] g, status_t st, logic [ID_W-1:0] fc);
		plan_row_t row;
		row = cmd_row(req_kind, id, req_strict);
		row.typed = 1'b1;
		row.want  = '{granted: g, status: st, free_cnt: fc};
		return row;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ID_W-1:0] pick_target(phase_t mode);
		logic [ID_W-1:0] span;
		int unsigned     r;
		span = (cfg_end > cfg_begin) ? cfg_end - cfg_begin : '0;
		r = $urandom_range(0, 99);
		if (r < 8 || span == 0)
			return $urandom;
		// odd offsets mostly split a range, which drives the list towards full
		if (mode == PH_FRAGMENT && r < 80 && span >= 4)
			return cfg_begin + 1 + 2 * $urandom_range(0, span / 2 - 1);
		if (span > 32'hFFFF_FFF0)
			return cfg_begin + $urandom_range(0, span - 1);
		return cfg_begin - 2 + $urandom_range(0, span + 3);
	endfunction

	task automatic issue_request(logic req_kind, logic [ID_W-1:0] id, logic req_strict,
		bit typed, grant_result_t want);
		grant_result_t pred;
		int unsigned   gap;
		start     <= 1'b1;
		kind      <= req_kind;
		target_id <= id;
		strict    <= req_strict;
		do @(posedge clk); while (busy);
		pred = serve_request(req_kind, id, req_strict);
		expect_result(typed ? want : pred);
		if (req_kind == KIND_ALLOC)
			alloc_sent++;
		else
			exclude_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
		if (start)
			start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		reg_we    <= 1'b1;
		reg_idx   <= idx;
		reg_wdata <= data;
		@(posedge clk);
		reg_we <= 1'b0;
		if (idx == REG_RANGE_BEGIN)
			cfg_begin = data;
		else
			cfg_end = data;
		reload_ranges();
		reg_writes++;
	endtask

	task automatic report_mismatch(string what, grant_result_t want, grant_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s, expected id %h status %0d free %h, got id %h status %0d free %h",
				$realtime, what, want.granted, want.status, want.free_cnt,
				got.granted, got.status, got.free_cnt);
	endtask

	always @(posedge clk) begin : result_check
		grant_result_t got;
		grant_result_t want;
		if (arst_n && done) begin
			got = '{granted: granted_id, status: status, free_cnt: free_count};
			status_seen[got.status]++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.granted !== want.granted)
					report_mismatch("granted_id", want, got);
				else if (got.status !== want.status)
					report_mismatch("status", want, got);
				else if (got.free_cnt !== want.free_cnt)
					report_mismatch("free_count", want, got);
			end
		end
	end

	initial begin : stimulus
		phase_t          mode;
		int unsigned     phase_len;
		int unsigned     span;
		logic [ID_W-1:0] new_begin;
		logic [ID_W-1:0] new_end;
		logic            req_kind;
		int unsigned     kind_pct;
		grant_result_t   none;

		none = '0;
		cfg_begin = '0;
		cfg_end   = '0;
		reload_ranges();

		add_plan_row(typed_row(KIND_ALLOC, '0, 1'b0, '0, ST_EXHAUSTED, '0));
		add_plan_row(typed_row(KIND_EXCLUDE, 32'd5, 1'b1, '0, ST_NOT_FREE, '0));
		add_plan_row(typed_row(KIND_EXCLUDE, 32'd5, 1'b0, '0, ST_OK, '0));
		// begin above end leaves the list empty
		add_plan_row(cfg_row(REG_RANGE_BEGIN, 32'd10));
		add_plan_row(typed_row(KIND_ALLOC, '0, 1'b1, '0, ST_EXHAUSTED, '0));
		add_plan_row(cfg_row(REG_RANGE_END, 32'd14));
		add_plan_row(typed_row(KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'd10, ST_OK, 32'd3));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'd12, 1'b1));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'd12, 1'b1));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'd13, 1'b0));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'd11, 1'b1));
		add_plan_row(typed_row(KIND_ALLOC, '0, 1'b0, '0, ST_EXHAUSTED, '0));
		// full width range
		add_plan_row(cfg_row(REG_RANGE_BEGIN, '0));
		add_plan_row(cfg_row(REG_RANGE_END, 32'hFFFF_FFFF));
		add_plan_row(typed_row(KIND_EXCLUDE, 32'hFFFF_FFFF, 1'b1, '0, ST_NOT_FREE,
			32'hFFFF_FFFF));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'hFFFF_FFFE, 1'b1));
		add_plan_row(cmd_row(KIND_EXCLUDE, '0, 1'b1));
		add_plan_row(cmd_row(KIND_ALLOC, '0, 1'b0));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'h7FFF_FFFF, 1'b0));
		add_plan_row(cmd_row(KIND_ALLOC, 32'h5555_AAAA, 1'b1));
		add_plan_row(cmd_row(KIND_EXCLUDE, 32'h8000_0000, 1'b1));
		add_plan_row(cfg_row(REG_RANGE_BEGIN, 32'hFFFF_FFFF));
		add_plan_row(typed_row(KIND_ALLOC, '0, 1'b0, '0, ST_EXHAUSTED, '0));
		// empty range with begin equal to end
		add_plan_row(cfg_row(REG_RANGE_END, 32'hFFFF_FFFF));
		add_plan_row(typed_row(KIND_EXCLUDE, 32'hFFFF_FFFF, 1'b1, '0, ST_NOT_FREE, '0));
		add_plan_row(cfg_row(REG_RANGE_BEGIN, 32'hFFFF_FFFE));
		add_plan_row(typed_row(KIND_ALLOC, '0, 1'b0, 32'hFFFF_FFFE, ST_OK, '0));
		add_plan_row(typed_row(KIND_ALLOC, '0, 1'b0, '0, ST_EXHAUSTED, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		quiet_phase = 1'b0;
		foreach (plan[n]) begin
			if (plan[n].is_cfg)
				write_register(plan[n].idx, plan[n].data);
			else
				issue_request(plan[n].kind, plan[n].id, plan[n].strict, plan[n].typed,
					plan[n].want);
		end

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mode = PH_FRAGMENT;
				8, 9:       mode = PH_NOISE;
				default:    mode = PH_MIXED;
			endcase
			quiet_phase = ($urandom_range(0, 4) == 0);
			case (mode)
				PH_FRAGMENT: begin
					span      = $urandom_range(150, 220);
					phase_len = $urandom_range(120, 180);
					kind_pct  = 10;
				end
				PH_MIXED: begin
					span      = $urandom_range(1, 40);
					phase_len = $urandom_range(20, 60);
					kind_pct  = 45;
				end
				default: begin
					span      = 0;
					phase_len = $urandom_range(10, 30);
					kind_pct  = 50;
				end
			endcase
			if (phase_len > unsigned'(RANDOM_ITEMS - random_items))
				phase_len = unsigned'(RANDOM_ITEMS - random_items);
			if (mode == PH_NOISE) begin
				case ($urandom_range(0, 3))
					0: begin
						new_begin = '0;
						new_end   = 32'hFFFF_FFFF;
					end
					1: begin
						new_begin = $urandom;
						new_end   = new_begin;
					end
					default: begin
						new_begin = $urandom;
						new_end   = $urandom;
					end
				endcase
			end else begin
				new_begin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
				if (new_begin > 32'hFFFF_FFFF - span)
					new_begin = 32'hFFFF_FFFF - span;
				new_end = new_begin + span;
			end
			case ($urandom_range(0, 9))
				0: write_register(REG_RANGE_END, new_end);
				1: write_register(REG_RANGE_BEGIN, new_begin);
				2, 3, 4: begin
					write_register(REG_RANGE_END, new_end);
					write_register(REG_RANGE_BEGIN, new_begin);
				end
				default: begin
					write_register(REG_RANGE_BEGIN, new_begin);
					write_register(REG_RANGE_END, new_end);
				end
			endcase
			repeat (phase_len) begin
				req_kind = ($urandom_range(0, 99) < kind_pct) ? KIND_ALLOC : KIND_EXCLUDE;
				issue_request(req_kind, pick_target(mode), $urandom_range(0, 1), 1'b0, none);
				random_items++;
			end
		end

		if (start)
			start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("ran %0d commands (%0d allocate, %0d exclude) over %0d register writes",
			alloc_sent + exclude_sent, alloc_sent, exclude_sent, reg_writes);
		$display("statuses returned: ok %0d, exhausted %0d, not free %0d, table full %0d",
			status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_NOT_FREE],
			status_seen[ST_TABLE_FULL]);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/lral_pkg.sv
hdl/lral_ram.sv
hdl/range_list_id_allocator_core.sv
tb/range_list_id_allocator_core_tb.sv
